// File: src/thfp_pkg.sv
// Shared types, constants and template tables for the text header frame parser.
package thfp_pkg;

  localparam int unsigned TLEN = 37;
  localparam int unsigned POS_W = 6;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_PAYLOAD = 2'd1,
    MODE_RESYNC  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    SLOT_LIT  = 2'd0,
    SLOT_NUM  = 2'd1,
    SLOT_NAME = 2'd2
  } slot_e;

  localparam logic [2:0] ERR_NAME     = 3'd5;
  localparam logic [2:0] ERR_NAME_LEN = 3'd7;

  localparam logic [7:0] CH_NL = 8'h0A;

  // Byte class from the front end.
  typedef struct packed {
    logic [7:0] data;
    logic       is_digit;
    logic       is_alpha;
    logic       is_nl;
    logic [3:0] digit;
  } cls_t;

  // Result record handed to the output register.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] v_major;
    logic [31:0] v_minor;
    logic [31:0] src;
    logic [31:0] seq;
    logic [31:0] len;
    logic [63:0] name;
    logic [3:0]  name_len;
    logic [7:0]  pbyte;
    logic        last;
    logic [2:0]  err;
  } res_t;

  function automatic slot_e tmpl_slot(input logic [POS_W-1:0] p);
    slot_e s;
    s = SLOT_LIT;
    unique case (p)
      6'd7, 6'd9, 6'd15, 6'd23, 6'd33: s = SLOT_NUM;
      6'd35:                           s = SLOT_NAME;
      default:                         s = SLOT_LIT;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] tmpl_char(input logic [POS_W-1:0] p);
    logic [7:0] c;
    c = 8'h00;
    unique case (p)
      6'd0: c = 8'h46;  6'd1: c = 8'h69;  6'd2: c = 8'h6E;  6'd3: c = 8'h64;
      6'd4: c = 8'h65;  6'd5: c = 8'h72;  6'd6: c = 8'h2F;  6'd8: c = 8'h2E;
      6'd10: c = 8'h20; 6'd11: c = 8'h73; 6'd12: c = 8'h72; 6'd13: c = 8'h63;
      6'd14: c = 8'h3D; 6'd16: c = 8'h20; 6'd17: c = 8'h73; 6'd18: c = 8'h65;
      6'd19: c = 8'h71; 6'd20: c = 8'h6E; 6'd21: c = 8'h6F; 6'd22: c = 8'h3D;
      6'd24: c = 8'h20; 6'd25: c = 8'h70; 6'd26: c = 8'h61; 6'd27: c = 8'h79;
      6'd28: c = 8'h6C; 6'd29: c = 8'h6F; 6'd30: c = 8'h61; 6'd31: c = 8'h64;
      6'd32: c = 8'h3D; 6'd34: c = 8'h20; 6'd36: c = 8'h0A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] tmpl_tag(input logic [POS_W-1:0] p);
    logic [2:0] t;
    if (p <= 6'd7)       t = 3'd0;
    else if (p <= 6'd9)  t = 3'd1;
    else if (p <= 6'd15) t = 3'd2;
    else if (p <= 6'd23) t = 3'd3;
    else if (p <= 6'd33) t = 3'd4;
    else if (p <= 6'd35) t = 3'd5;
    else                 t = 3'd6;
    return t;
  endfunction

endpackage

// File: src/thfp_front.sv
// Front end: accepts stream bytes, classifies them and fills a short queue.
module thfp_front
  import thfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_data_i,
  output logic       q_valid_o,
  input  logic       q_ready_i,
  output cls_t       q_data_o
);

  cls_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  cls_t       c;

  always_comb begin
    c.data     = s_data_i;
    c.is_digit = (s_data_i >= 8'h30) && (s_data_i <= 8'h39);
    c.is_alpha = ((s_data_i >= 8'h41) && (s_data_i <= 8'h5A)) ||
                 ((s_data_i >= 8'h61) && (s_data_i <= 8'h7A));
    c.is_nl    = (s_data_i == CH_NL);
    c.digit    = s_data_i[3:0];
  end

  assign s_ready_o = (cnt_q != 2'd2);
  assign push      = s_valid_i && s_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: src/thfp_back.sv
// Back end: template matcher, field capture, payload pass and output register.
module thfp_back
  import thfp_pkg::*;
#(
  parameter int unsigned NAME_CHARS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  output logic q_ready_o,
  input  cls_t q_data_i,
  output logic m_valid_o,
  input  logic m_ready_i,
  output res_t m_data_o
);

  mode_e             mode_q, mode_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              seen_q, seen_d;
  logic [31:0]       acc_q, acc_d;
  logic [31:0]       fld_q [5];
  logic [31:0]       fld_d [5];
  logic [63:0]       name_q, name_d;
  logic [3:0]        ncnt_q, ncnt_d;
  logic [31:0]       rem_q, rem_d;
  logic              ov_q;
  res_t              out_q;
  logic              emit;
  res_t              res;

  logic              take;
  logic [POS_W-1:0]  p0, p1;
  slot_e             sl;
  logic              lit_ok;
  logic [31:0]       acc_x10;

  assign q_ready_o = !ov_q || m_ready_i;
  assign take      = q_valid_i && q_ready_o;
  assign m_valid_o = ov_q;
  assign m_data_o  = out_q;
  // acc * 10 as acc * 8 + acc * 2, wrapping at 32 bits
  assign acc_x10   = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0};

  always_comb begin
    mode_d = mode_q; pos_d = pos_q; seen_d = seen_q; acc_d = acc_q;
    fld_d  = fld_q;  name_d = name_q; ncnt_d = ncnt_q; rem_d = rem_q;
    emit   = 1'b0;
    res    = '0;
    p0     = (pos_q >= POS_W'(TLEN)) ? '0 : pos_q;
    p1     = p0;
    sl     = tmpl_slot(p0);
    lit_ok = 1'b1;
    if (mode_q == MODE_PAYLOAD) begin
      emit       = 1'b1;
      res.kind   = KIND_PAYLOAD;
      res.pbyte  = q_data_i.data;
      if (rem_q <= 32'd1) begin
        rem_d = '0; res.last = 1'b1; mode_d = MODE_HEADER;
        pos_d = '0; seen_d = 1'b0; acc_d = '0; name_d = '0; ncnt_d = '0;
      end else begin
        rem_d = rem_q - 32'd1;
      end
    end else if (mode_q == MODE_RESYNC) begin
      if (q_data_i.is_nl) begin
        mode_d = MODE_HEADER;
        pos_d = '0; seen_d = 1'b0; acc_d = '0; name_d = '0; ncnt_d = '0;
      end
    end else begin
      mode_d = MODE_HEADER;
      if (sl == SLOT_NUM && q_data_i.is_digit) begin
        acc_d  = acc_x10 + {28'd0, q_data_i.digit};
        seen_d = 1'b1; pos_d = p0; lit_ok = 1'b0;
      end else if (sl == SLOT_NUM && !seen_q) begin
        emit = 1'b1; res.kind = KIND_ERROR; res.err = tmpl_tag(p0); lit_ok = 1'b0;
      end else if (sl == SLOT_NAME && q_data_i.is_alpha) begin
        lit_ok = 1'b0;
        if (ncnt_q >= 4'(NAME_CHARS)) begin
          emit = 1'b1; res.kind = KIND_ERROR; res.err = ERR_NAME_LEN;
        end else begin
          name_d = name_q | ({56'd0, q_data_i.data} << {ncnt_q[2:0], 3'b000});
          ncnt_d = ncnt_q + 4'd1; pos_d = p0;
        end
      end else if (sl == SLOT_NAME && ncnt_q == 4'd0) begin
        emit = 1'b1; res.kind = KIND_ERROR; res.err = ERR_NAME; lit_ok = 1'b0;
      end else if (sl == SLOT_NUM) begin
        fld_d[tmpl_tag(p0)] = acc_q;
        acc_d = '0; seen_d = 1'b0; p1 = p0 + POS_W'(1);
      end else if (sl == SLOT_NAME) begin
        p1 = p0 + POS_W'(1);
      end
      if (lit_ok) begin
        if (q_data_i.data != tmpl_char(p1)) begin
          emit = 1'b1; res.kind = KIND_ERROR; res.err = tmpl_tag(p1);
        end else if (p1 + POS_W'(1) >= POS_W'(TLEN)) begin
          emit = 1'b1; res.kind = KIND_HEADER;
          res.v_major = fld_d[0]; res.v_minor = fld_d[1]; res.src = fld_d[2];
          res.seq = fld_d[3]; res.len = fld_d[4];
          res.name = name_d; res.name_len = ncnt_d;
          rem_d  = fld_d[4];
          mode_d = (fld_d[4] == 32'd0) ? MODE_HEADER : MODE_PAYLOAD;
          pos_d = '0; seen_d = 1'b0; acc_d = '0; name_d = '0; ncnt_d = '0;
        end else begin
          pos_d = p1 + POS_W'(1);
        end
      end
      if (emit && res.kind == KIND_ERROR) begin
        mode_d = q_data_i.is_nl ? MODE_HEADER : MODE_RESYNC;
        pos_d = '0; seen_d = 1'b0; acc_d = '0; name_d = '0; ncnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_HEADER; pos_q <= '0; seen_q <= 1'b0; acc_q <= '0;
      name_q <= '0; ncnt_q <= '0; rem_q <= '0; ov_q <= 1'b0;
      for (int i = 0; i < 5; i++) fld_q[i] <= '0;
    end else begin
      if (take) begin
        mode_q <= mode_d; pos_q <= pos_d; seen_q <= seen_d; acc_q <= acc_d;
        name_q <= name_d; ncnt_q <= ncnt_d; rem_q <= rem_d; fld_q <= fld_d;
      end
      if (take && emit)   ov_q <= 1'b1;
      else if (m_ready_i) ov_q <= 1'b0;
    end
  end

endmodule

// File: src/text_header_frame_parser.sv
// Top level of the text header frame parser.
// While the queue has room, one byte is taken per cycle on the slave stream
// and matched against the text header template (prefix, major.minor, src=,
// seqno=, payload=, a space, a letter name, newline). A good header yields
// one header record, then the announced number of payload bytes are passed
// with tlast on the final one. A mismatch yields one error record naming the
// failed part and bytes are dropped through the next newline. A two-entry
// queue between classifier and matcher and a registered output let both
// sides stall independently. A byte is held in a queue entry and its result
// in the output register; one byte per cycle sustained while neither stalls.
module text_header_frame_parser
  import thfp_pkg::*;
#(
  parameter int unsigned NAME_CHARS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // in_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // version_major, version_minor, source_id, sequence_number, payload_length,
  // name_chars, name_length, payload_byte, error_field, zero pad (lowest first)
  output logic [239:0] m_axis_tdata,
  output logic         m_axis_tlast,   // last_of_payload
  output logic [1:0]   m_axis_tuser    // kind
);

  logic q_valid, q_ready;
  cls_t q_data;
  res_t r;

  thfp_front u_front (
    .clk_i, .rst_ni,
    .s_valid_i (s_axis_tvalid), .s_ready_o (s_axis_tready), .s_data_i (s_axis_tdata),
    .q_valid_o (q_valid), .q_ready_i (q_ready), .q_data_o (q_data)
  );

  thfp_back #(.NAME_CHARS(NAME_CHARS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid), .q_ready_o (q_ready), .q_data_i (q_data),
    .m_valid_o (m_axis_tvalid), .m_ready_i (m_axis_tready), .m_data_o (r)
  );

  assign m_axis_tdata = {1'b0, r.err, r.pbyte, r.name_len, r.name,
                         r.len, r.seq, r.src, r.v_minor, r.v_major};
  assign m_axis_tlast = r.last;
  assign m_axis_tuser = r.kind;

endmodule

// File: tb/thfp_checker.sv
// Checker for the text header frame parser: predicts results from accepted requests and compares.
`timescale 1ns / 100ps
module thfp_checker
  import thfp_pkg::*;
#(
  parameter int unsigned NAME_CHARS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [239:0] m_axis_tdata,
  input  logic         m_axis_tlast,
  input  logic [1:0]   m_axis_tuser,
  output int           fail_count,
  output int           pending_count,
  output int           hdr_seen,
  output int           pay_seen,
  output int           err_seen
);

  typedef struct {
    logic [1:0]   kind;
    logic [239:0] data;
    logic         last;
  } exp_t;

  exp_t       exp_q[$];
  mode_e      p_mode;
  logic [5:0] p_pos;
  logic       p_dig;
  logic [31:0] p_acc;
  logic [31:0] p_fld[5];
  logic [63:0] p_name;
  logic [3:0]  p_ncnt;
  logic [31:0] p_rem;

  assign pending_count = exp_q.size();

  function automatic logic [7:0] lit_char(input int p);
    string s;
    s = {$sformatf("%c%c%c%c%c%c%c", 8'h46, 8'h69, 8'h6E, 8'h64, 8'h65, 8'h72, 8'h2F),
         "#.# src=# seqno=# payload=# @\n"};
    return s[p];
  endfunction

  function automatic int tag_of(input int p);
    if (p <= 7) return 0;
    if (p <= 9) return 1;
    if (p <= 15) return 2;
    if (p <= 23) return 3;
    if (p <= 33) return 4;
    if (p <= 35) return 5;
    return 6;
  endfunction

  task automatic enqueue(input exp_t e);
    exp_q = {exp_q, e};
  endtask

  task automatic clear_match();
    p_pos = 0; p_dig = 0; p_acc = 0; p_name = 0; p_ncnt = 0;
  endtask

  task automatic push_err(input logic [7:0] b, input int code);
    exp_t e;
    e.kind = KIND_ERROR; e.last = 0;
    e.data = '0; e.data[238:236] = code[2:0];
    enqueue(e);
    clear_match();
    p_mode = (b == CH_NL) ? MODE_HEADER : MODE_RESYNC;
  endtask

  // Advance the parser state by one request byte.
  task automatic parse_byte(input logic [7:0] b);
    exp_t e;
    int   pos;
    logic [7:0] t;
    if (p_mode == MODE_PAYLOAD) begin
      e.kind = KIND_PAYLOAD; e.data = '0; e.data[235:228] = b;
      e.last = (p_rem <= 1);
      enqueue(e);
      if (p_rem <= 1) begin
        p_rem = 0; p_mode = MODE_HEADER; clear_match();
      end else begin
        p_rem--;
      end
      return;
    end
    if (p_mode == MODE_RESYNC) begin
      if (b == CH_NL) begin
        p_mode = MODE_HEADER; clear_match();
      end
      return;
    end
    p_mode = MODE_HEADER;
    pos = (p_pos >= TLEN) ? 0 : p_pos;
    t = lit_char(pos);
    if (t == "#") begin
      if (b >= "0" && b <= "9") begin
        p_acc = p_acc * 10 + 32'(b - "0"); p_dig = 1; p_pos = pos;
        return;
      end
      if (!p_dig) begin
        push_err(b, tag_of(pos)); return;
      end
      p_fld[tag_of(pos)] = p_acc; p_acc = 0; p_dig = 0; pos++;
    end else if (t == "@") begin
      if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) begin
        if (p_ncnt >= NAME_CHARS) begin
          push_err(b, ERR_NAME_LEN); return;
        end
        p_name |= 64'(b) << (8 * p_ncnt); p_ncnt++; p_pos = pos;
        return;
      end
      if (p_ncnt == 0) begin
        push_err(b, ERR_NAME); return;
      end
      pos++;
    end
    if (b != lit_char(pos)) begin
      push_err(b, tag_of(pos)); return;
    end
    pos++;
    if (pos >= TLEN) begin
      e.kind = KIND_HEADER; e.last = 0;
      e.data = {1'b0, 3'b0, 8'b0, p_ncnt, p_name,
                p_fld[4], p_fld[3], p_fld[2], p_fld[1], p_fld[0]};
      enqueue(e);
      p_rem = p_fld[4];
      p_mode = (p_rem == 0) ? MODE_HEADER : MODE_PAYLOAD;
      clear_match();
      return;
    end
    p_pos = pos;
  endtask

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    exp_t e;
    if (!rst_ni) begin
      exp_q.delete();
      p_mode = MODE_HEADER; clear_match(); p_rem = 0;
      foreach (p_fld[i]) p_fld[i] = 0;
      fail_count = 0; hdr_seen = 0; pay_seen = 0; err_seen = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (exp_q.size() == 0) begin
          report($sformatf("unexpected result kind %0d", m_axis_tuser));
        end else begin
          e = exp_q.pop_front();
          case (e.kind)
            KIND_HEADER:  hdr_seen++;
            KIND_PAYLOAD: pay_seen++;
            default:      err_seen++;
          endcase
          if (m_axis_tuser != e.kind)
            report($sformatf("kind %0d want %0d", m_axis_tuser, e.kind));
          else if (m_axis_tdata !== e.data)
            report($sformatf("data %h want %h", m_axis_tdata, e.data));
          else if (m_axis_tlast !== e.last)
            report($sformatf("last %b want %b", m_axis_tlast, e.last));
        end
      end
    end
  end

endmodule

// File: tb/tb_text_header_frame_parser.sv
// Testbench top for the text header frame parser: stimulus, stall phases and verdict.
`timescale 1ns / 100ps
module tb_text_header_frame_parser;
  import thfp_pkg::*;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [239:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic [1:0]   m_axis_tuser;

  int fail_count, pending_count, hdr_seen, pay_seen, err_seen;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int sent = 0;
  int phase_end;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS = 1750;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  text_header_frame_parser dut (.*);

  thfp_checker chk (.*);

  // Receiver stalls at random per phase.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Run guard: a stuck handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Fixed seven-byte header prefix.
  function automatic string pfx();
    return $sformatf("%c%c%c%c%c%c%c", 8'h46, 8'h69, 8'h6E, 8'h64, 8'h65, 8'h72, 8'h2F);
  endfunction

  // Send one request byte, with optional random idling before it.
  // tready is sampled mid-cycle, where it is stable up to the next edge.
  task automatic send_byte(input byte unsigned b);
    logic ok;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= b;
    ok = 0;
    while (!ok) begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end
    sent++;
  endtask

  task automatic send_str(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  function automatic string rand_num();
    string s;
    int n;
    n = $urandom_range(4) == 0 ? $urandom_range(12, 20) : $urandom_range(1, 4);
    s = "";
    repeat (n) s = {s, string'(byte'("0" + $urandom_range(9)))};
    return s;
  endfunction

  function automatic string rand_name(input int n);
    string s;
    byte c;
    s = "";
    repeat (n) begin
      c = $urandom_range(1) ? byte'("A" + $urandom_range(25))
                            : byte'("a" + $urandom_range(25));
      s = {s, string'(c)};
    end
    return s;
  endfunction

  // Well-formed header, then its payload with arbitrary bytes.
  task automatic send_frame(input int plen, input int nlen);
    send_str({pfx(), rand_num(), ".", rand_num(), " src=", rand_num(),
              " seqno=", rand_num(), " payload=", $sformatf("%0d", plen),
              " ", rand_name(nlen), "\n"});
    repeat (plen) send_byte($urandom_range(255));
  endtask

  // Header with one byte replaced at random, then sometimes an extra newline for resync.
  task automatic send_broken();
    string s;
    int k;
    s = {pfx(), rand_num(), ".", rand_num(), " src=", rand_num(), " seqno=",
         rand_num(), " payload=0 ", rand_name($urandom_range(1, 10)), "\n"};
    k = $urandom_range(s.len() - 1);
    s[k] = byte'($urandom_range(255));
    send_str(s);
    if ($urandom_range(1)) send_byte(8'h0A);
  endtask

  // Hold the sender until every expected result has come out.
  task automatic drain();
    s_axis_tvalid <= 0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: extremes, every error code, empty payload, long name.
    send_str({pfx(), "4294967295.0 src=4294967296 seqno=99999999999 payload=0 Z\n"});
    send_frame(1, 8);
    send_frame(3, 1);
    send_str({pfx(), ".1 src=1 seqno=1 payload=0 a\n"});
    send_str({pfx(), "1.x src=1 seqno=1 payload=0 a\n"});
    send_str({pfx(), "1.1 srx=1 seqno=1 payload=0 a\n"});
    send_str({pfx(), "1.1 src=1 seqno= payload=0 a\n"});
    send_str({pfx(), "1.1 src=1 seqno=1 payload=z a\n"});
    send_str({pfx(), "1.1 src=1 seqno=1 payload=0 1\n"});
    send_str({pfx(), "1.1 src=1 seqno=1 payload=0 ab!"});
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h0A);
    send_str({pfx(), "1.1 src=1 seqno=1 payload=0 abcdefghi\n"});
    send_str({pfx().substr(0, 1), "\n"});
    drain();

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 48 : (ph == 3) ? 24 : 0;
      recv_stall_pct = (ph == 2) ? 48 : (ph == 3) ? 24 : 0;
      phase_end = ITEMS * (ph + 1) / 4;
      do begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: send_frame($urandom_range(0, 6),
                                       $urandom_range(4) == 0 ? 8 : $urandom_range(1, 7));
          6, 7: send_broken();
          8: repeat ($urandom_range(1, 10)) send_byte($urandom_range(255));
          default: send_frame(300, 2);
        endcase
      end while (sent < phase_end);
      drain();
    end
    recv_stall_pct = 0;
    drain();
    repeat (20) @(posedge clk_i);

    $display("sent %0d bytes; results: %0d headers, %0d payload bytes, %0d errors",
             sent, hdr_seen, pay_seen, err_seen);
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/thfp_pkg.sv
src/thfp_front.sv
src/thfp_back.sv
src/text_header_frame_parser.sv
tb/thfp_checker.sv
tb/tb_text_header_frame_parser.sv
